>>> rtl/plin_pkg.sv
`timescale 1ns / 1ps

package plin_pkg;

  // Default build: sixteen breakpoints, signed Q16.16
  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned DATA_WIDTH_DEF  = 32;

  // Fixed field widths
  localparam int unsigned CNT_W  = 5;  // point_count register
  localparam int unsigned SLOT_W = 4;  // point_index field
  localparam int unsigned STAT_W = 3;  // status field

  // Input operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_EMPTY  = 3'd0,
    STAT_LOW    = 3'd1,
    STAT_HIGH   = 3'd2,
    STAT_INTERP = 3'd3,
    STAT_NOSEG  = 3'd4
  } plin_status_e;

endpackage

>>> rtl/plin_alu.sv
`timescale 1ns / 1ps

// Shared add/subtract unit; carries every difference, multiply step,
// divide step and the final sum of the interpolator.
module plin_alu #(
  parameter int unsigned WIDTH = plin_pkg::DATA_WIDTH_DEF + 2
) (
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic             sub_i,
  output logic [WIDTH-1:0] sum_o
);

  logic [WIDTH-1:0] b_inv;

  // Two's complement subtract: invert b and add one
  assign b_inv = b_i ^ {WIDTH{sub_i}};
  assign sum_o = a_i + b_inv + WIDTH'(sub_i);

endmodule

>>> rtl/plin_table.sv
`timescale 1ns / 1ps

// Breakpoint store: one write port, one read port with registered data.
module plin_table #(
  parameter int unsigned DEPTH      = plin_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = plin_pkg::DATA_WIDTH_DEF,
  parameter int unsigned ADDR_WIDTH = $clog2(plin_pkg::TABLE_DEPTH_DEF)
) (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [ADDR_WIDTH-1:0]        wr_addr_i,
  input  logic signed [DATA_WIDTH-1:0] wr_x_i,
  input  logic signed [DATA_WIDTH-1:0] wr_y_i,
  input  logic [ADDR_WIDTH-1:0]        rd_addr_i,
  output logic signed [DATA_WIDTH-1:0] rd_x_o,
  output logic signed [DATA_WIDTH-1:0] rd_y_o
);

  logic [2*DATA_WIDTH-1:0] point_mem [DEPTH];
  logic [2*DATA_WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      point_mem[wr_addr_i] <= {wr_x_i, wr_y_i};
    end
  end

  // Read port, data registered in the cycle after the address
  always_ff @(posedge clk_i) begin
    rd_data_q <= point_mem[rd_addr_i];
  end

  assign rd_x_o = rd_data_q[2*DATA_WIDTH-1:DATA_WIDTH];
  assign rd_y_o = rd_data_q[DATA_WIDTH-1:0];

endmodule

>>> rtl/piecewise_linear_interpolator.sv
`timescale 1ns / 1ps

// Piecewise linear interpolator over a table of up to TABLE_DEPTH breakpoints
// in signed fixed point (Q16.16 at the default 32-bit width). A write beat
// (op 0) stores one (x, y) point; writes to a slot at or above TABLE_DEPTH
// are dropped. A query beat (op 1) returns one result beat: status 0 with
// value 0 for an empty table, the first or last ordinate when query_x is at
// or beyond the ends (status 1 or 2), the interpolated ordinate on the first
// segment holding query_x (status 3), or 0 with status 4 when the table is
// not ordered and no segment holds it. The input stalls while a query is in
// flight, also while its result waits on the output. An interpolating query
// walks the table, one entry per cycle through the single read port, then a
// bit-serial multiply and a bit-serial restoring divide, one bit per cycle
// each, on one shared adder. The user must write point_count only while the
// block is idle; the block itself does not enforce it. Counts above
// TABLE_DEPTH act as TABLE_DEPTH.
module piecewise_linear_interpolator #(
  parameter int unsigned TABLE_DEPTH = plin_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH  = plin_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [plin_pkg::CNT_W-1:0]          cfg_data_i,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                op_i,
  input  logic [plin_pkg::SLOT_W-1:0]         point_index_i,
  input  logic signed [DATA_WIDTH-1:0]        point_x_i,
  input  logic signed [DATA_WIDTH-1:0]        point_y_i,
  input  logic signed [DATA_WIDTH-1:0]        query_x_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [DATA_WIDTH-1:0]        value_o,
  output logic [plin_pkg::STAT_W-1:0]         status_o
);

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned IW = (AW > plin_pkg::CNT_W) ? AW : plin_pkg::CNT_W;
  localparam int unsigned SW = W + 2;      // adder width
  localparam int unsigned PW = 2 * W + 1;  // product / dividend width
  localparam int unsigned CW = $clog2(DATA_WIDTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_WALK,
    S_DY,
    S_MAG,
    S_DXQ,
    S_DXS,
    S_MUL,
    S_DIV,
    S_NEGQ,
    S_SUM,
    S_RESULT
  } state_e;

  state_e state_q, state_d;

  logic [plin_pkg::CNT_W-1:0] point_count_q;
  logic                       out_valid_q;

  // datapath registers
  logic signed [W-1:0]    x_q;
  logic [IW-1:0]          last_q;
  logic [IW-1:0]          idx_q;
  logic signed [W-1:0]    prev_x_q, prev_y_q;
  logic signed [W-1:0]    cur_x_q, cur_y_q;
  logic [SW-1:0]          dy_q;
  logic                   neg_q;
  logic [W:0]             mag_q;
  logic [W-1:0]           dxs_q;
  logic [PW-1:0]          acc_q;
  logic [CW-1:0]          cnt_q;
  logic signed [W-1:0]    res_value_q;
  plin_pkg::plin_status_e res_status_q;
  logic signed [W-1:0]    value_q;
  plin_pkg::plin_status_e status_q;

  // combinational signals
  logic                       in_acc;
  logic                       out_free;
  logic [plin_pkg::CNT_W-1:0] n_clip;
  logic [IW-1:0]              last_d;
  logic [IW-1:0]              idx_inc;
  logic                       slot_ok;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [AW-1:0]              rd_addr;
  logic signed [W-1:0]        rd_x, rd_y;
  logic                       hit;
  logic                       cnt_last;
  logic [SW-1:0]              alu_a, alu_b, alu_sum;
  logic                       alu_sub;
  logic                       div_bit;
  logic [W:0]                 div_rem;
  logic                       sat_ovf;
  logic signed [W-1:0]        sat_value;

  // Handshake
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

  // Effective point count and last index
  assign n_clip  = (32'(point_count_q) > TABLE_DEPTH) ?
                   plin_pkg::CNT_W'(TABLE_DEPTH) : point_count_q;
  assign last_d  = IW'(n_clip) - IW'(1);
  assign idx_inc = idx_q + IW'(1);
  assign slot_ok = (32'(point_index_i) < TABLE_DEPTH);
  assign wr_addr = AW'(point_index_i);

  // Segment test on the entry just read
  assign hit      = (x_q >= prev_x_q) && (x_q < rd_x);
  assign cnt_last = (cnt_q == CW'(W - 1));

  // Divide step: shift in next dividend bit, subtract divisor if it fits
  assign div_bit = !alu_sum[SW-1];
  assign div_rem = div_bit ? alu_sum[W:0] : acc_q[PW-2:W-1];

  // Saturate the final sum to W bits
  assign sat_ovf   = !((alu_sum[SW-1:W-1] == '0) || (alu_sum[SW-1:W-1] == '1));
  assign sat_value = !sat_ovf ? alu_sum[W-1:0] :
                     (alu_sum[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});

  plin_table #(
    .DEPTH      (TABLE_DEPTH),
    .DATA_WIDTH (W),
    .ADDR_WIDTH (AW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_x_i    (point_x_i),
    .wr_y_i    (point_y_i),
    .rd_addr_i (rd_addr),
    .rd_x_o    (rd_x),
    .rd_y_o    (rd_y)
  );

  plin_alu #(
    .WIDTH (SW)
  ) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum)
  );

  // Sequencer: next state, read address, adder operands
  always_comb begin
    state_d = state_q;
    wr_en   = 1'b0;
    rd_addr = '0;
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (op_i == plin_pkg::OP_WRITE) begin
            wr_en = slot_ok;
          end else if (n_clip == '0) begin
            state_d = S_RESULT;
          end else begin
            state_d = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        if (x_q <= rd_x) begin
          state_d = S_RESULT;
        end else begin
          rd_addr = last_q[AW-1:0];
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        if (x_q >= rd_x) begin
          state_d = S_RESULT;
        end else begin
          rd_addr = AW'(1);
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (hit) begin
          state_d = S_DY;
        end else if (idx_q == last_q) begin
          state_d = S_RESULT;
        end else begin
          rd_addr = idx_inc[AW-1:0];
        end
      end
      S_DY: begin
        alu_a   = {{2{cur_y_q[W-1]}}, cur_y_q};
        alu_b   = {{2{prev_y_q[W-1]}}, prev_y_q};
        alu_sub = 1'b1;
        state_d = S_MAG;
      end
      S_MAG: begin
        alu_a   = neg_q ? '0 : dy_q;
        alu_b   = neg_q ? dy_q : '0;
        alu_sub = neg_q;
        state_d = S_DXQ;
      end
      S_DXQ: begin
        alu_a   = {{2{x_q[W-1]}}, x_q};
        alu_b   = {{2{prev_x_q[W-1]}}, prev_x_q};
        alu_sub = 1'b1;
        state_d = S_DXS;
      end
      S_DXS: begin
        alu_a   = {{2{cur_x_q[W-1]}}, cur_x_q};
        alu_b   = {{2{prev_x_q[W-1]}}, prev_x_q};
        alu_sub = 1'b1;
        state_d = S_MUL;
      end
      S_MUL: begin
        // add multiplicand into the upper half when the low bit is set
        alu_a = {1'b0, acc_q[PW-1:W]};
        alu_b = acc_q[0] ? {1'b0, mag_q} : '0;
        if (cnt_last) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        alu_a   = {1'b0, acc_q[PW-2:W-1]};
        alu_b   = {2'b00, dxs_q};
        alu_sub = 1'b1;
        if (cnt_last) begin
          state_d = S_NEGQ;
        end
      end
      S_NEGQ: begin
        alu_a   = neg_q ? '0 : {2'b00, acc_q[W-1:0]};
        alu_b   = neg_q ? {2'b00, acc_q[W-1:0]} : '0;
        alu_sub = neg_q;
        state_d = S_SUM;
      end
      S_SUM: begin
        alu_a   = {{2{prev_y_q[W-1]}}, prev_y_q};
        alu_b   = dy_q;
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  // State, config register and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      point_count_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        point_count_q <= cfg_data_i;
      end
      if ((state_q == S_RESULT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (op_i == plin_pkg::OP_QUERY)) begin
          x_q          <= query_x_i;
          last_q       <= last_d;
          idx_q        <= IW'(1);
          res_value_q  <= '0;
          res_status_q <= plin_pkg::STAT_EMPTY;
        end
      end
      S_FIRST: begin
        prev_x_q <= rd_x;
        prev_y_q <= rd_y;
        if (x_q <= rd_x) begin
          res_value_q  <= rd_y;
          res_status_q <= plin_pkg::STAT_LOW;
        end
      end
      S_LAST: begin
        if (x_q >= rd_x) begin
          res_value_q  <= rd_y;
          res_status_q <= plin_pkg::STAT_HIGH;
        end
      end
      S_WALK: begin
        if (hit) begin
          cur_x_q <= rd_x;
          cur_y_q <= rd_y;
        end else if (idx_q == last_q) begin
          res_value_q  <= '0;
          res_status_q <= plin_pkg::STAT_NOSEG;
        end else begin
          prev_x_q <= rd_x;
          prev_y_q <= rd_y;
          idx_q    <= idx_inc;
        end
      end
      S_DY: begin
        dy_q  <= alu_sum;
        neg_q <= alu_sum[SW-1];
      end
      S_MAG: begin
        mag_q <= alu_sum[W:0];
      end
      S_DXQ: begin
        acc_q <= {{(W+1){1'b0}}, alu_sum[W-1:0]};
        cnt_q <= '0;
      end
      S_DXS: begin
        dxs_q <= alu_sum[W-1:0];
      end
      S_MUL: begin
        acc_q <= {alu_sum, acc_q[W-1:1]};
        cnt_q <= cnt_last ? '0 : cnt_q + CW'(1);
      end
      S_DIV: begin
        acc_q <= {div_rem, acc_q[W-2:0], div_bit};
        cnt_q <= cnt_last ? '0 : cnt_q + CW'(1);
      end
      S_NEGQ: begin
        dy_q <= alu_sum;
      end
      S_SUM: begin
        res_value_q  <= sat_value;
        res_status_q <= plin_pkg::STAT_INTERP;
      end
      S_RESULT: begin
        if (out_free) begin
          value_q  <= res_value_q;
          status_q <= res_status_q;
        end
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // Walk index stays inside the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> ((idx_q != '0) && (idx_q <= last_q)))
    else $error("walk index out of range");

  // Segment width is never zero once the multiply starts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (dxs_q != '0))
    else $error("zero divisor");

  // Partial remainder stays below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (acc_q[PW-1:W] < {1'b0, dxs_q}))
    else $error("remainder not below divisor");

  // Quotient magnitude stays below the segment rise
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NEGQ) |-> (({1'b0, acc_q[W-1:0]} < mag_q) || (mag_q == '0)))
    else $error("quotient exceeds segment rise");
`endif

endmodule
